// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

// ===== rtl/nss_pkg.sv =====
// ----------------------------------------------------------------------------
// nss_pkg
// Types, constants and helper functions of the noisy sensor sample model.
// ----------------------------------------------------------------------------
package nss_pkg;

   localparam int FRAC_BITS = 16;

   localparam int WIDE_W = 68;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam logic [28:0] TWO_LN2_Q28     = 29'd372130559;
   localparam logic [34:0] W_FLOOR_Q28     = 35'd22251437259;
   localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic [63:0] DRAW_FLOOR      = 64'd18;
   localparam logic [66:0] Q28_HALF        = 67'd134217728;

   localparam logic [5:0] LOG_LAST    = 6'd27;
   localparam logic [5:0] SQRT_FIRST  = 6'd31;
   localparam logic [5:0] CORDIC_LAST = 6'd27;
   localparam logic [5:0] DIV_LAST    = 6'd33;

   typedef enum logic [2:0] {
      CSR_DRIFT_RATE  = 3'd0,
      CSR_NOISE_SCALE = 3'd1,
      CSR_QUANT_STEP  = 3'd2,
      CSR_SEED        = 3'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DRIFT,
      S_GEN_A,
      S_GEN_B,
      S_NORM,
      S_LOG,
      S_LNMUL,
      S_SQRT,
      S_ANGLE,
      S_CORDIC,
      S_GAUSS,
      S_NOISE,
      S_DIV_INIT,
      S_DIV,
      S_QMUL,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [31:0] value;
      logic        sat;
   } clip_type;

   function automatic clip_type clip32(wide_type v);
      clip_type r;
      r.sat   = 1'b0;
      r.value = v[31:0];
      if (v > wide_type'(64'sh7FFFFFFF)) begin
         r.sat   = 1'b1;
         r.value = 32'h7FFFFFFF;
      end else if (v < -wide_type'(64'sh80000000)) begin
         r.sat   = 1'b1;
         r.value = 32'h80000000;
      end
      return r;
   endfunction

   function automatic logic [63:0] xorshift64(logic [63:0] s);
      logic [63:0] x;
      x = s;
      x = x ^ (x << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      return x;
   endfunction

   // arctan(2^-i) in Q2.30
   function automatic logic [29:0] atan_q30(logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:  r = 30'h3243F6A8;
         5'd1:  r = 30'h1DAC6705;
         5'd2:  r = 30'h0FADBAFC;
         5'd3:  r = 30'h07F56EA6;
         5'd4:  r = 30'h03FEAB76;
         5'd5:  r = 30'h01FFD55B;
         5'd6:  r = 30'h00FFFAAA;
         5'd7:  r = 30'h007FFF55;
         5'd8:  r = 30'h003FFFEA;
         5'd9:  r = 30'h001FFFFD;
         5'd10: r = 30'h000FFFFF;
         5'd11: r = 30'h0007FFFF;
         5'd12: r = 30'h0003FFFF;
         5'd13: r = 30'h0001FFFF;
         5'd14: r = 30'h0000FFFF;
         5'd15: r = 30'h00007FFF;
         5'd16: r = 30'h00003FFF;
         5'd17: r = 30'h00001FFF;
         5'd18: r = 30'h00000FFF;
         5'd19: r = 30'h000007FF;
         5'd20: r = 30'h000003FF;
         5'd21: r = 30'h000001FF;
         5'd22: r = 30'h000000FF;
         5'd23: r = 30'h0000007F;
         5'd24: r = 30'h0000003F;
         5'd25: r = 30'h0000001F;
         5'd26: r = 30'h0000000F;
         5'd27: r = 30'h00000008;
         default: r = 30'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/nss_req_if.sv =====
// ----------------------------------------------------------------------------
// nss_req_if
// Input sample channel: valid/ready with ideal value and elapsed time.
// ----------------------------------------------------------------------------
interface nss_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] ideal_value;
   logic [31:0]        elapsed_time;

   modport source (output valid, output ideal_value, output elapsed_time, input ready);
   modport sink   (input valid, input ideal_value, input elapsed_time, output ready);
endinterface

// ===== rtl/nss_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nss_rsp_if
// Result channel: valid/ready with sample and saturation flag.
// ----------------------------------------------------------------------------
interface nss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;
   logic               saturated;

   modport source (output valid, output sample, output saturated, input ready);
   modport sink   (input valid, input sample, input saturated, output ready);
endinterface

// ===== rtl/noisy_sensor_sample_model_unit.sv =====
// ----------------------------------------------------------------------------
// noisy_sensor_sample_model_unit
// Drift, Box-Muller Gaussian noise and quantization of a Q16.16 sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one sample (ideal_value, elapsed_time) per transfer. The
//   unit takes one sample at a time; req_if.ready is high only when idle.
//   rsp_if returns exactly one result (sample, saturated) per sample.
//   csr_we/csr_index/csr_data write drift_rate (0), noise_scale (1),
//   quant_step (2) and seed (3); a seed write also loads the generator.
//   Indexes above 3 are ignored. Write registers only while idle.
// Sequence, from input transfer to rsp_if.valid:
//   drift; with noise on, two draws, normalize, log and ln multiply
//   (skipped when u1 is floored), square root, angle, CORDIC, Gaussian
//   scaling and noise add; with quantization on, a 34-step divider and
//   a multiply. All multiplies go through one shared 35x32 multiplier;
//   the log squaring loop, square root, CORDIC and divider each run one
//   step per cycle under the sequencer.
//   A new sample is accepted in the cycle after the result transfer.
// Reset clears the configuration registers to zero and the generator to 1.
// If the receiver stalls, the result holds on rsp_if until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module noisy_sensor_sample_model_unit (
   input  logic        clock,
   input  logic        reset,
   nss_req_if.sink     req_if,
   nss_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   nss_pkg::state_type state_ff, state_in;

   logic signed [31:0] drift_ff;
   logic [31:0]        scale_ff, step_ff;
   logic [63:0]        gen_ff, gen_in;

   logic signed [31:0] tv_ff, tv_in;
   logic [31:0]        et_ff, et_in;
   logic [31:0]        v_ff, v_in;
   logic               sat_ff, sat_in;
   logic [63:0]        a_ff, a_in, b_ff, b_in;
   logic [5:0]         p_ff, p_in;
   logic [30:0]        m_ff, m_in;
   logic [27:0]        frac_ff, frac_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [63:0]        sx_ff, sx_in, res_ff, res_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [30:0]        gm_ff, gm_in;
   logic               gneg_ff, gneg_in, vneg_ff, vneg_in;
   logic [33:0]        rem_ff, rem_in, quo_ff, quo_in;

   // shared multiplier
   logic [34:0] mul_a;
   logic [31:0] mul_b;
   logic [66:0] mul_p;

   logic [31:0]        drift_mag;
   logic [34:0]        log_len;
   logic signed [33:0] cos_xr, cos_yr, cos_q28, cos_abs;

   assign mul_p = 67'(mul_a) * 67'(mul_b);

   assign drift_mag = drift_ff[31] ? (~drift_ff + 32'd1) : drift_ff;
   assign log_len   = {7'd64 - {1'b0, p_ff}, 28'd0} - {7'd0, frac_ff};

   // CORDIC output rounded to Q4.28 and folded by quadrant
   assign cos_xr = (x_ff + 34'sd2) >>> 2;
   assign cos_yr = (y_ff + 34'sd2) >>> 2;

   always_comb begin
      case (b_ff[63:62])
         2'd0:    cos_q28 = cos_xr;
         2'd1:    cos_q28 = -cos_yr;
         2'd2:    cos_q28 = -cos_xr;
         default: cos_q28 = cos_yr;
      endcase
   end

   assign cos_abs = cos_q28[33] ? -cos_q28 : cos_q28;

   assign req_if.ready     = (state_ff == nss_pkg::S_IDLE);
   assign rsp_if.valid     = (state_ff == nss_pkg::S_OUT);
   assign rsp_if.sample    = v_ff;
   assign rsp_if.saturated = sat_ff;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         nss_pkg::S_DRIFT: begin
            mul_a = 35'(drift_mag);
            mul_b = et_ff;
         end
         nss_pkg::S_LOG: begin
            mul_a = 35'(m_ff);
            mul_b = 32'(m_ff);
         end
         nss_pkg::S_LNMUL: begin
            mul_a = log_len;
            mul_b = 32'(nss_pkg::TWO_LN2_Q28);
         end
         nss_pkg::S_ANGLE: begin
            mul_a = 35'(b_ff[61:30]);
            mul_b = 32'(nss_pkg::HALF_PI_Q30);
         end
         nss_pkg::S_GAUSS: begin
            mul_a = 35'(res_ff[31:0]);
            mul_b = 32'(cos_abs[30:0]);
         end
         nss_pkg::S_NOISE: begin
            mul_a = 35'(gm_ff);
            mul_b = scale_ff;
         end
         nss_pkg::S_QMUL: begin
            mul_a = 35'(quo_ff[31:0]);
            mul_b = step_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nss_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff <= '0;
         scale_ff <= '0;
         step_ff  <= '0;
         gen_ff   <= 64'd1;
      end else begin
         gen_ff <= gen_in;
         if (csr_we) begin
            unique case (csr_index)
               nss_pkg::CSR_DRIFT_RATE:  drift_ff <= csr_data[31:0];
               nss_pkg::CSR_NOISE_SCALE: scale_ff <= csr_data[31:0];
               nss_pkg::CSR_QUANT_STEP:  step_ff  <= csr_data[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tv_ff   <= tv_in;
      et_ff   <= et_in;
      v_ff    <= v_in;
      sat_ff  <= sat_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      p_ff    <= p_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      sx_ff   <= sx_in;
      res_ff  <= res_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      gm_ff   <= gm_in;
      gneg_ff <= gneg_in;
      vneg_ff <= vneg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   always_comb begin
      logic [66:0]        rnd;
      logic [66:0]        mag;
      nss_pkg::wide_type  sum;
      nss_pkg::clip_type  clp;
      logic [63:0]        gx;
      logic [31:0]        sq;
      logic [63:0]        bitv, trial;
      logic signed [33:0] xs, ys, at;
      logic [31:0]        vm;
      logic [33:0]        shifted, den;

      state_in = state_ff;
      gen_in   = gen_ff;
      tv_in    = tv_ff;
      et_in    = et_ff;
      v_in     = v_ff;
      sat_in   = sat_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      sx_in    = sx_ff;
      res_in   = res_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      gm_in    = gm_ff;
      gneg_in  = gneg_ff;
      vneg_in  = vneg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;

      rnd     = '0;
      mag     = '0;
      sum     = '0;
      clp     = '0;
      gx      = nss_pkg::xorshift64(gen_ff);
      sq      = mul_p[61:30];
      bitv    = 64'd1 << {cnt_ff[4:0], 1'b0};
      trial   = res_ff + bitv;
      xs      = x_ff >>> cnt_ff[4:0];
      ys      = y_ff >>> cnt_ff[4:0];
      at      = $signed({4'd0, nss_pkg::atan_q30(cnt_ff[4:0])});
      vm      = v_ff[31] ? (~v_ff + 32'd1) : v_ff;
      den     = {1'b0, step_ff, 1'b0};
      shifted = {rem_ff[32:0], quo_ff[33]};

      unique case (state_ff)
         nss_pkg::S_IDLE: begin
            if (req_if.valid) begin
               tv_in    = req_if.ideal_value;
               et_in    = req_if.elapsed_time;
               sat_in   = 1'b0;
               state_in = nss_pkg::S_DRIFT;
            end
         end
         nss_pkg::S_DRIFT: begin
            rnd    = (mul_p + (67'd1 << (nss_pkg::FRAC_BITS - 1))) >> nss_pkg::FRAC_BITS;
            sum    = nss_pkg::wide_type'(tv_ff) +
                     (drift_ff[31] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd}));
            clp    = nss_pkg::clip32(sum);
            v_in   = clp.value;
            sat_in = clp.sat;
            if (scale_ff != 32'd0) begin
               state_in = nss_pkg::S_GEN_A;
            end else if (step_ff != 32'd0) begin
               state_in = nss_pkg::S_DIV_INIT;
            end else begin
               state_in = nss_pkg::S_OUT;
            end
         end
         nss_pkg::S_GEN_A: begin
            a_in     = gx;
            gen_in   = (gx == 64'd0) ? 64'd1 : gx;
            state_in = nss_pkg::S_GEN_B;
         end
         nss_pkg::S_GEN_B: begin
            b_in   = gx;
            gen_in = (gx == 64'd0) ? 64'd1 : gx;
            if (a_ff <= nss_pkg::DRAW_FLOOR) begin
               // u1 floored at 1e-18
               sx_in    = {1'b0, nss_pkg::W_FLOOR_Q28, 28'd0};
               res_in   = '0;
               cnt_in   = nss_pkg::SQRT_FIRST;
               state_in = nss_pkg::S_SQRT;
            end else begin
               p_in     = 6'd63;
               state_in = nss_pkg::S_NORM;
            end
         end
         nss_pkg::S_NORM: begin
            if (a_ff[63]) begin
               m_in     = a_ff[63:33];
               frac_in  = '0;
               cnt_in   = '0;
               state_in = nss_pkg::S_LOG;
            end else if (a_ff[63:56] == 8'd0) begin
               a_in = a_ff << 8;
               p_in = p_ff - 6'd8;
            end else begin
               a_in = a_ff << 1;
               p_in = p_ff - 6'd1;
            end
         end
         nss_pkg::S_LOG: begin
            // log2 fraction bits by repeated squaring in Q1.30
            frac_in = {frac_ff[26:0], sq[31]};
            m_in    = sq[31] ? sq[31:1] : sq[30:0];
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == nss_pkg::LOG_LAST) begin
               state_in = nss_pkg::S_LNMUL;
            end
         end
         nss_pkg::S_LNMUL: begin
            rnd      = mul_p + nss_pkg::Q28_HALF;
            sx_in    = {1'b0, rnd[62:28], 28'd0};
            res_in   = '0;
            cnt_in   = nss_pkg::SQRT_FIRST;
            state_in = nss_pkg::S_SQRT;
         end
         nss_pkg::S_SQRT: begin
            if (sx_ff >= trial) begin
               sx_in  = sx_ff - trial;
               res_in = (res_ff >> 1) + bitv;
            end else begin
               res_in = res_ff >> 1;
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = nss_pkg::S_ANGLE;
            end
         end
         nss_pkg::S_ANGLE: begin
            z_in     = $signed({3'd0, mul_p[62:32]});
            x_in     = nss_pkg::CORDIC_GAIN_Q30;
            y_in     = '0;
            cnt_in   = '0;
            state_in = nss_pkg::S_CORDIC;
         end
         nss_pkg::S_CORDIC: begin
            if (!z_ff[33]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == nss_pkg::CORDIC_LAST) begin
               state_in = nss_pkg::S_GAUSS;
            end
         end
         nss_pkg::S_GAUSS: begin
            rnd     = mul_p + nss_pkg::Q28_HALF;
            gneg_in = cos_q28[33];
            gm_in   = (rnd[66:59] != 8'd0) ? 31'h7FFFFFFF : rnd[58:28];
            state_in = nss_pkg::S_NOISE;
         end
         nss_pkg::S_NOISE: begin
            mag    = (mul_p + nss_pkg::Q28_HALF) >> 28;
            sum    = nss_pkg::wide_type'($signed(v_ff)) +
                     (gneg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));
            clp    = nss_pkg::clip32(sum);
            v_in   = clp.value;
            sat_in = sat_ff | clp.sat;
            state_in = (step_ff != 32'd0) ? nss_pkg::S_DIV_INIT : nss_pkg::S_OUT;
         end
         nss_pkg::S_DIV_INIT: begin
            // n = floor((2|v| + step) / (2 step))
            vneg_in  = v_ff[31];
            quo_in   = {1'b0, vm, 1'b0} + 34'(step_ff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = nss_pkg::S_DIV;
         end
         nss_pkg::S_DIV: begin
            if (shifted >= den) begin
               rem_in = shifted - den;
               quo_in = {quo_ff[32:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[32:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == nss_pkg::DIV_LAST) begin
               state_in = nss_pkg::S_QMUL;
            end
         end
         nss_pkg::S_QMUL: begin
            sum    = vneg_ff ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});
            clp    = nss_pkg::clip32(sum);
            v_in   = clp.value;
            sat_in = sat_ff | clp.sat;
            state_in = nss_pkg::S_OUT;
         end
         nss_pkg::S_OUT: begin
            if (rsp_if.ready) begin
               state_in = nss_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nss_pkg::S_IDLE;
         end
      endcase

      // a seed write takes priority over a generator step
      if (csr_we && (csr_index == nss_pkg::CSR_SEED)) begin
         gen_in = csr_data;
      end
   end

   `ASSERT_SAME(a_no_overlap, clock, reset, rsp_if.valid, !req_if.ready)
   `ASSERT_NEXT(a_start_drift, clock, reset, req_if.valid && req_if.ready,
                state_ff == nss_pkg::S_DRIFT)
   `ASSERT_NEXT(a_gen_nonzero, clock, reset,
                state_ff == nss_pkg::S_GEN_A && !csr_we, gen_ff != 64'd0)
   `ASSERT_NEXT(a_rsp_done, clock, reset, rsp_if.valid && rsp_if.ready,
                state_ff == nss_pkg::S_IDLE)

endmodule
